### rtl/core/fau_pkg.sv
package fau_pkg;

    localparam int OPERAND_WIDTH = 16;
    localparam int RES_WIDTH     = 32;
    localparam int CNT_WIDTH     = $clog2(RES_WIDTH);

    typedef enum logic [1:0] {
        MODE_ADD   = 2'd0,
        MODE_MUL   = 2'd1,
        MODE_RECIP = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        DSEL_REM = 2'd0,
        DSEL_QN  = 2'd1,
        DSEL_QD  = 2'd2
    } div_sel_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'd0,
        S_MUL  = 3'd1,
        S_FORM = 3'd2,
        S_TEST = 3'd3,
        S_REM  = 3'd4,
        S_QN   = 3'd5,
        S_QD   = 3'd6,
        S_OUT  = 3'd7
    } state_t;

    typedef struct packed {
        logic     load;
        logic     mul;
        logic     form;
        logic     div_start;
        div_sel_t div_sel;
        logic     gcd_step;
        logic     qn_save;
        logic     out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic need_reduce;
        logic x_zero;
        logic y_zero;
        logic div_done;
        logic div_busy;
    } dp_status_t;

endpackage

### rtl/core/fau_div.sv
module fau_div
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     start,
    input  logic signed [fau_pkg::RES_WIDTH-1:0]     dividend,
    input  logic signed [fau_pkg::RES_WIDTH-1:0]     divisor,
    output logic                                     busy,
    output logic                                     done,
    output logic signed [fau_pkg::RES_WIDTH-1:0]     quotient,
    output logic signed [fau_pkg::RES_WIDTH-1:0]     remainder
);

    localparam int W = fau_pkg::RES_WIDTH;

    logic                                busy_reg;
    logic                                done_reg;
    logic [fau_pkg::CNT_WIDTH-1:0]       cnt_reg;
    logic [W-1:0]                        q_reg;
    logic [W-1:0]                        r_reg;
    logic [W-1:0]                        dvs_reg;
    logic                                neg_q_reg;
    logic                                neg_r_reg;

    logic [W-1:0]                        dvd_mag;
    logic [W-1:0]                        dvs_mag;
    logic [W:0]                          r_shift;
    logic                                ge;
    logic [W:0]                          r_sub;
    logic [W-1:0]                        r_next;
    logic [W-1:0]                        q_next;

    always_comb
    begin
        dvd_mag = dividend[W-1] ? W'(-dividend) : W'(dividend);
        dvs_mag = divisor[W-1]  ? W'(-divisor)  : W'(divisor);
        // one restoring step: shift in the next dividend bit, subtract if it fits
        r_shift = {r_reg, q_reg[W-1]};
        ge      = (r_shift >= {1'b0, dvs_reg});
        r_sub   = r_shift - {1'b0, dvs_reg};
        r_next  = ge ? r_sub[W-1:0] : r_shift[W-1:0];
        q_next  = {q_reg[W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= fau_pkg::CNT_WIDTH'(W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg     <= dvd_mag;
            r_reg     <= '0;
            dvs_reg   <= dvs_mag;
            neg_q_reg <= dividend[W-1] ^ divisor[W-1];
            neg_r_reg <= dividend[W-1];
        end
        else if (busy_reg)
        begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    // remainder takes the sign of the dividend; quotient magnitude 2^31 wraps
    assign quotient  = neg_q_reg ? -$signed(q_reg) : $signed(q_reg);
    assign remainder = neg_r_reg ? -$signed(r_reg) : $signed(r_reg);
    assign busy      = busy_reg;
    assign done      = done_reg;

endmodule

### rtl/core/fau_dp.sv
module fau_dp
(
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  fau_pkg::dp_cmd_t                             cmd,
    output fau_pkg::dp_status_t                          status,
    input  logic [1:0]                                   mode,
    input  logic signed [fau_pkg::OPERAND_WIDTH-1:0]     a_num,
    input  logic signed [fau_pkg::OPERAND_WIDTH-1:0]     a_den,
    input  logic signed [fau_pkg::OPERAND_WIDTH-1:0]     b_num,
    input  logic signed [fau_pkg::OPERAND_WIDTH-1:0]     b_den,
    output logic signed [fau_pkg::RES_WIDTH-1:0]         res_num,
    output logic signed [fau_pkg::RES_WIDTH-1:0]         res_den,
    output logic                                         zero_gcd
);

    localparam int W = fau_pkg::RES_WIDTH;

    logic [1:0]                                  mode_reg;
    logic signed [fau_pkg::OPERAND_WIDTH-1:0]    an_reg;
    logic signed [fau_pkg::OPERAND_WIDTH-1:0]    ad_reg;
    logic signed [fau_pkg::OPERAND_WIDTH-1:0]    bn_reg;
    logic signed [fau_pkg::OPERAND_WIDTH-1:0]    bd_reg;
    logic signed [W-1:0]                         pa_reg;
    logic signed [W-1:0]                         pb_reg;
    logic signed [W-1:0]                         pd_reg;
    logic signed [W-1:0]                         n_reg;
    logic signed [W-1:0]                         d_reg;
    logic signed [W-1:0]                         x_reg;
    logic signed [W-1:0]                         y_reg;
    logic signed [W-1:0]                         qn_reg;
    logic                                        reduce_reg;
    logic signed [W-1:0]                         res_num_reg;
    logic signed [W-1:0]                         res_den_reg;
    logic                                        zero_gcd_reg;

    logic signed [W-1:0]                         an_w;
    logic signed [W-1:0]                         ad_w;
    logic signed [W-1:0]                         bn_w;
    logic signed [W-1:0]                         bd_w;
    logic signed [W-1:0]                         pa_next;
    logic signed [W-1:0]                         n_next;
    logic signed [W-1:0]                         d_next;
    logic                                        reduce_next;
    logic signed [W-1:0]                         div_dvd;
    logic signed [W-1:0]                         div_dvs;
    logic                                        div_busy;
    logic                                        div_done;
    logic signed [W-1:0]                         div_quo;
    logic signed [W-1:0]                         div_rem;

    always_comb
    begin
        an_w = W'(an_reg);
        ad_w = W'(ad_reg);
        bn_w = W'(bn_reg);
        bd_w = W'(bd_reg);
        // add needs a_num*b_den, multiply needs a_num*b_num
        pa_next = (mode_reg == fau_pkg::MODE_ADD) ? an_w * bd_w : an_w * bn_w;

        case (mode_reg)
            fau_pkg::MODE_ADD:
            begin
                if (ad_reg == bd_reg)
                begin
                    n_next      = an_w + bn_w;
                    d_next      = ad_w;
                    reduce_next = 1'b0;
                end
                else
                begin
                    n_next      = pa_reg + pb_reg;
                    d_next      = pd_reg;
                    reduce_next = 1'b1;
                end
            end
            fau_pkg::MODE_MUL:
            begin
                n_next      = pa_reg;
                d_next      = pd_reg;
                reduce_next = 1'b1;
            end
            default:
            begin
                n_next      = ad_w;
                d_next      = an_w;
                reduce_next = 1'b0;
            end
        endcase

        case (cmd.div_sel)
            fau_pkg::DSEL_QN:
            begin
                div_dvd = n_reg;
                div_dvs = x_reg;
            end
            fau_pkg::DSEL_QD:
            begin
                div_dvd = d_reg;
                div_dvs = x_reg;
            end
            default:
            begin
                div_dvd = x_reg;
                div_dvs = y_reg;
            end
        endcase
    end

    fau_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= mode;
            an_reg   <= a_num;
            ad_reg   <= a_den;
            bn_reg   <= b_num;
            bd_reg   <= b_den;
        end
        if (cmd.mul)
        begin
            pa_reg <= pa_next;
            pb_reg <= bn_w * ad_w;
            pd_reg <= ad_w * bd_w;
        end
        if (cmd.form)
        begin
            n_reg      <= n_next;
            d_reg      <= d_next;
            x_reg      <= n_next;
            y_reg      <= d_next;
            reduce_reg <= reduce_next;
        end
        if (cmd.gcd_step)
        begin
            x_reg <= y_reg;
            y_reg <= div_rem;
        end
        if (cmd.qn_save)
        begin
            qn_reg <= div_quo;
        end
        if (cmd.out_load)
        begin
            if (!reduce_reg)
            begin
                res_num_reg  <= n_reg;
                res_den_reg  <= d_reg;
                zero_gcd_reg <= 1'b0;
            end
            else if (x_reg == '0)
            begin
                res_num_reg  <= '0;
                res_den_reg  <= '0;
                zero_gcd_reg <= 1'b1;
            end
            else
            begin
                res_num_reg  <= qn_reg;
                res_den_reg  <= div_quo;
                zero_gcd_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        status.need_reduce = reduce_reg;
        status.x_zero      = (x_reg == '0);
        status.y_zero      = (y_reg == '0);
        status.div_done    = div_done;
        status.div_busy    = div_busy;
    end

    assign res_num  = res_num_reg;
    assign res_den  = res_den_reg;
    assign zero_gcd = zero_gcd_reg;

endmodule

### rtl/core/fau_ctrl.sv
module fau_ctrl
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    output logic                    out_valid,
    input  logic                    out_stall,
    output fau_pkg::dp_cmd_t        cmd,
    input  fau_pkg::dp_status_t     status
);

    fau_pkg::state_t state_reg;
    fau_pkg::state_t state_next;
    logic            out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fau_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        cmd         = '0;
        cmd.div_sel = fau_pkg::DSEL_REM;
        state_next  = state_reg;
        in_stall    = (state_reg != fau_pkg::S_IDLE);

        unique case (state_reg)
            fau_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = fau_pkg::S_MUL;
                end
            end
            fau_pkg::S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = fau_pkg::S_FORM;
            end
            fau_pkg::S_FORM:
            begin
                cmd.form   = 1'b1;
                state_next = fau_pkg::S_TEST;
            end
            fau_pkg::S_TEST:
            begin
                if (!status.need_reduce)
                begin
                    state_next = fau_pkg::S_OUT;
                end
                else if (!status.y_zero)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = fau_pkg::DSEL_REM;
                    state_next    = fau_pkg::S_REM;
                end
                else if (status.x_zero)
                begin
                    state_next = fau_pkg::S_OUT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = fau_pkg::DSEL_QN;
                    state_next    = fau_pkg::S_QN;
                end
            end
            fau_pkg::S_REM:
            begin
                if (status.div_done)
                begin
                    cmd.gcd_step = 1'b1;
                    state_next   = fau_pkg::S_TEST;
                end
            end
            fau_pkg::S_QN:
            begin
                if (status.div_done)
                begin
                    cmd.qn_save   = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = fau_pkg::DSEL_QD;
                    state_next    = fau_pkg::S_QD;
                end
            end
            fau_pkg::S_QD:
            begin
                if (status.div_done)
                begin
                    state_next = fau_pkg::S_OUT;
                end
            end
            fau_pkg::S_OUT:
            begin
                // hold the result until the output register frees up
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = fau_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = fau_pkg::S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

### rtl/core/fraction_arithmetic_unit.sv
// Reciprocal and equal-denominator add skip reduction; a reduced result runs one
// Euclid remainder step per division, then divides numerator and denominator by
// the gcd unless it is zero. Every division goes through one shared radix-2 divider.
// One item at a time: the next item is taken the cycle after the result loads, and
// a result waits to load while out_stall holds the pending one.
// Reset (rst_n, async, active low) returns the sequencer to idle and drops out_valid.
module fraction_arithmetic_unit
(
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         in_valid,
    output logic                                         in_stall,
    input  logic [1:0]                                   mode,
    input  logic signed [fau_pkg::OPERAND_WIDTH-1:0]     a_num,
    input  logic signed [fau_pkg::OPERAND_WIDTH-1:0]     a_den,
    input  logic signed [fau_pkg::OPERAND_WIDTH-1:0]     b_num,
    input  logic signed [fau_pkg::OPERAND_WIDTH-1:0]     b_den,
    output logic                                         out_valid,
    input  logic                                         out_stall,
    output logic signed [fau_pkg::RES_WIDTH-1:0]         res_num,
    output logic signed [fau_pkg::RES_WIDTH-1:0]         res_den,
    output logic                                         zero_gcd
);

    fau_pkg::dp_cmd_t    cmd;
    fau_pkg::dp_status_t status;

    fau_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    fau_dp u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .mode     (mode),
        .a_num    (a_num),
        .a_den    (a_den),
        .b_num    (b_num),
        .b_den    (b_den),
        .res_num  (res_num),
        .res_den  (res_den),
        .zero_gcd (zero_gcd)
    );

    // a zero gcd always comes with a zero fraction
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_gcd |-> res_num == '0 && res_den == '0)
        else $error("zero_gcd result is not zero");

    // no item enters while the divider is working
    assert property (@(posedge clk) disable iff (!rst_n)
        status.div_busy |-> in_stall)
        else $error("input open while divider busy");

    // the divider is never restarted mid-operation
    assert property (@(posedge clk) disable iff (!rst_n)
        status.div_busy |-> !cmd.div_start)
        else $error("divider restarted while busy");

    // a result is replaced only after it was taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(res_num) && $stable(res_den))
        else $error("pending result lost");

endmodule

### dv/fau_checker.sv
module fau_checker
(
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       in_valid,
    input  logic                                       in_stall,
    input  logic [1:0]                                 mode,
    input  logic signed [fau_pkg::OPERAND_WIDTH-1:0]   a_num,
    input  logic signed [fau_pkg::OPERAND_WIDTH-1:0]   a_den,
    input  logic signed [fau_pkg::OPERAND_WIDTH-1:0]   b_num,
    input  logic signed [fau_pkg::OPERAND_WIDTH-1:0]   b_den,
    input  logic                                       out_valid,
    input  logic                                       out_stall,
    input  logic signed [fau_pkg::RES_WIDTH-1:0]       res_num,
    input  logic signed [fau_pkg::RES_WIDTH-1:0]       res_den,
    input  logic                                       zero_gcd,
    output int                                         fail_count,
    output int                                         outstanding
);

    typedef struct packed {
        logic signed [fau_pkg::RES_WIDTH-1:0] num;
        logic signed [fau_pkg::RES_WIDTH-1:0] den;
        logic                                 zero;
    } fraction_t;

    fraction_t expected_q[$];

    initial
    begin
        fail_count  = 0;
        outstanding = 0;
    end

    function automatic logic signed [fau_pkg::RES_WIDTH-1:0] to_word(longint v);
        return v[fau_pkg::RES_WIDTH-1:0];
    endfunction

    function automatic fraction_t predict_fraction(
        logic [1:0]                               op,
        logic signed [fau_pkg::OPERAND_WIDTH-1:0] an,
        logic signed [fau_pkg::OPERAND_WIDTH-1:0] ad,
        logic signed [fau_pkg::OPERAND_WIDTH-1:0] bn,
        logic signed [fau_pkg::OPERAND_WIDTH-1:0] bd
    );
        fraction_t f;
        longint    n;
        longint    d;
        longint    x;
        longint    y;
        longint    r;
        bit        needs_gcd;
        needs_gcd = 1'b1;
        if (op == fau_pkg::MODE_ADD && ad == bd)
        begin
            n         = longint'(an) + longint'(bn);
            d         = ad;
            needs_gcd = 1'b0;
        end
        else if (op == fau_pkg::MODE_ADD)
        begin
            n = longint'(an) * bd + longint'(bn) * ad;
            d = longint'(ad) * bd;
        end
        else if (op == fau_pkg::MODE_MUL)
        begin
            n = longint'(an) * bn;
            d = longint'(ad) * bd;
        end
        else
        begin
            // mode 3 falls through here as a reciprocal too
            n         = ad;
            d         = an;
            needs_gcd = 1'b0;
        end
        // wrap intermediates to the result width before reduction
        n      = to_word(n);
        d      = to_word(d);
        f.num  = n[fau_pkg::RES_WIDTH-1:0];
        f.den  = d[fau_pkg::RES_WIDTH-1:0];
        f.zero = 1'b0;
        if (needs_gcd)
        begin
            x = n;
            y = d;
            // truncated remainder, sign of the dividend; gcd keeps its sign
            while (y != 0)
            begin
                r = x % y;
                x = y;
                y = r;
            end
            if (x == 0)
            begin
                f.num  = '0;
                f.den  = '0;
                f.zero = 1'b1;
            end
            else
            begin
                f.num = to_word(n / x);
                f.den = to_word(d / x);
            end
        end
        return f;
    endfunction

    always @(posedge clk)
    begin
        fraction_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                expected_q.push_back(predict_fraction(mode, a_num, a_den, b_num, b_den));
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result with nothing expected: res_num %0d res_den %0d zero_gcd %0b",
                           res_num, res_den, zero_gcd);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (res_num !== want.num)
                    begin
                        $error("res_num: expected %0d, got %0d", $signed(want.num), res_num);
                        fail_count = fail_count + 1;
                    end
                    if (res_den !== want.den)
                    begin
                        $error("res_den: expected %0d, got %0d", $signed(want.den), res_den);
                        fail_count = fail_count + 1;
                    end
                    if (zero_gcd !== want.zero)
                    begin
                        $error("zero_gcd: expected %0b, got %0b", want.zero, zero_gcd);
                        fail_count = fail_count + 1;
                    end
                end
            end
            outstanding <= expected_q.size();
        end
    end

endmodule

### dv/fraction_arithmetic_unit_tb.sv
module fraction_arithmetic_unit_tb;

    localparam logic [1:0] MODE_UNUSED  = 2'd3;
    localparam int         RANDOM_ITEMS = 1050;
    localparam int         IDLE_LIMIT   = 12000;
    localparam int         DRAIN_CYCLES = 1800;

    logic                                       clk       = 1'b0;
    logic                                       rst_n     = 1'b0;
    logic                                       in_valid  = 1'b0;
    logic                                       in_stall;
    logic [1:0]                                 mode      = fau_pkg::MODE_ADD;
    logic signed [fau_pkg::OPERAND_WIDTH-1:0]   a_num     = '0;
    logic signed [fau_pkg::OPERAND_WIDTH-1:0]   a_den     = '0;
    logic signed [fau_pkg::OPERAND_WIDTH-1:0]   b_num     = '0;
    logic signed [fau_pkg::OPERAND_WIDTH-1:0]   b_den     = '0;
    logic                                       out_valid;
    logic                                       out_stall = 1'b0;
    logic signed [fau_pkg::RES_WIDTH-1:0]       res_num;
    logic signed [fau_pkg::RES_WIDTH-1:0]       res_den;
    logic                                       zero_gcd;
    int                                         fail_count;
    int                                         outstanding;

    bit in_quiet  = 1'b0;
    bit out_quiet = 1'b0;
    int stall_left = 0;
    int stall_cycle = 0;
    int idle_cycles = 0;

    logic signed [fau_pkg::OPERAND_WIDTH-1:0] corners [5] =
        '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff, 16'sh0001};

    fraction_arithmetic_unit i_dut (.*);

    fau_checker i_checker (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap(bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [fau_pkg::OPERAND_WIDTH-1:0] pick_operand();
        int v;
        case ($urandom_range(0, 9))
            0:          return corners[$urandom_range(0, 4)];
            1, 2, 3, 4:
            begin
                // small values keep the gcd loop short
                v = $urandom_range(0, 48) - 24;
                return v[fau_pkg::OPERAND_WIDTH-1:0];
            end
            default:    return fau_pkg::OPERAND_WIDTH'($urandom);
        endcase
    endfunction

    task automatic send_item(
        input logic [1:0]                               op,
        input logic signed [fau_pkg::OPERAND_WIDTH-1:0] an,
        input logic signed [fau_pkg::OPERAND_WIDTH-1:0] ad,
        input logic signed [fau_pkg::OPERAND_WIDTH-1:0] bn,
        input logic signed [fau_pkg::OPERAND_WIDTH-1:0] bd
    );
        int gap;
        gap = pick_gap(in_quiet);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= op;
        a_num    <= an;
        a_den    <= ad;
        b_num    <= bn;
        b_den    <= bd;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // result side back-pressure, with calm stretches now and then
    always @(posedge clk)
    begin
        stall_cycle = stall_cycle + 1;
        if (stall_cycle % 512 == 0)
            out_quiet = ($urandom_range(0, 3) == 0);
        if (stall_left == 0)
            stall_left = pick_gap(out_quiet);
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("fraction_arithmetic_unit_tb failed");
            $finish;
        end
    end

    initial
    begin
        logic [1:0]                               op;
        logic signed [fau_pkg::OPERAND_WIDTH-1:0] an;
        logic signed [fau_pkg::OPERAND_WIDTH-1:0] ad;
        logic signed [fau_pkg::OPERAND_WIDTH-1:0] bn;
        logic signed [fau_pkg::OPERAND_WIDTH-1:0] bd;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // equal denominators: add numerators, no reduction
        send_item(fau_pkg::MODE_ADD, 16'sd3, 16'sd7, 16'sd4, 16'sd7);
        send_item(fau_pkg::MODE_ADD, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        send_item(fau_pkg::MODE_ADD, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_item(fau_pkg::MODE_ADD, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        // cross-multiplied add with reduction
        send_item(fau_pkg::MODE_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd3);
        send_item(fau_pkg::MODE_ADD, 16'sd1, -16'sd6, 16'sd1, 16'sd3);
        send_item(fau_pkg::MODE_ADD, 16'sh8000, 16'sh8000, 16'sh8000, -16'sd32767);
        send_item(fau_pkg::MODE_ADD, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
        // zero gcd through add and multiply
        send_item(fau_pkg::MODE_ADD, 16'sd0, 16'sd0, 16'sd0, 16'sd5);
        send_item(fau_pkg::MODE_MUL, 16'sd0, 16'sd3, 16'sd5, 16'sd0);
        // zero denominator passes through as a value
        send_item(fau_pkg::MODE_ADD, 16'sd3, 16'sd0, 16'sd1, 16'sd2);
        send_item(fau_pkg::MODE_MUL, 16'sd6, 16'sd4, 16'sd2, 16'sd0);
        // multiply
        send_item(fau_pkg::MODE_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        send_item(fau_pkg::MODE_MUL, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
        send_item(fau_pkg::MODE_MUL, 16'sd2, -16'sd3, 16'sd9, 16'sd4);
        send_item(fau_pkg::MODE_MUL, 16'sd0, 16'sd5, 16'sd3, 16'sd7);
        send_item(fau_pkg::MODE_MUL, -16'sd1, -16'sd1, -16'sd1, -16'sd1);
        // reciprocal, second operand ignored
        send_item(fau_pkg::MODE_RECIP, 16'sd5, -16'sd7, 16'sh7fff, 16'sh8000);
        send_item(fau_pkg::MODE_RECIP, 16'sh8000, 16'sh7fff, 16'sd0, 16'sd0);
        send_item(fau_pkg::MODE_RECIP, 16'sd0, 16'sd0, 16'shffff, 16'shffff);
        // the spare mode code decodes as a reciprocal
        send_item(MODE_UNUSED, 16'sd12, 16'sd18, 16'sd3, 16'sd4);
        send_item(MODE_UNUSED, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 64 == 0)
                in_quiet = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: op = fau_pkg::MODE_ADD;
                4, 5, 6, 7: op = fau_pkg::MODE_MUL;
                8:          op = fau_pkg::MODE_RECIP;
                default:    op = MODE_UNUSED;
            endcase
            an = pick_operand();
            ad = pick_operand();
            bn = pick_operand();
            bd = pick_operand();
            // equal denominators take the unreduced add path
            if (op == fau_pkg::MODE_ADD && $urandom_range(0, 3) == 0)
                bd = ad;
            send_item(op, an, ad, bn, bd);
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && outstanding == 0)
            $display("fraction_arithmetic_unit_tb passed");
        else
            $display("fraction_arithmetic_unit_tb failed");
        $finish;
    end

endmodule

### filelist.f
rtl/core/fau_pkg.sv
rtl/core/fau_div.sv
rtl/core/fau_dp.sv
rtl/core/fau_ctrl.sv
rtl/core/fraction_arithmetic_unit.sv
dv/fau_checker.sv
dv/fraction_arithmetic_unit_tb.sv
